@@ sv/ddct_pkg.sv @@
package ddct_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_MISSING  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 3'd5;

    localparam logic [15:0] SPINUP_DELAY_RST = 16'd50000;
    localparam logic [15:0] BYTE_DELAY_RST   = 16'd150;
    localparam logic [15:0] SIDE_LENGTH_RST  = 16'd65500;

    localparam logic [14:0] ADDR_TIMER_LO   = 15'h4020;
    localparam logic [14:0] ADDR_TIMER_HI   = 15'h4021;
    localparam logic [14:0] ADDR_TIMER_CTRL = 15'h4022;
    localparam logic [14:0] ADDR_MASTER_IO  = 15'h4023;
    localparam logic [14:0] ADDR_WRITE_DATA = 15'h4024;
    localparam logic [14:0] ADDR_CONTROL    = 15'h4025;
    localparam logic [14:0] ADDR_CONNECTOR  = 15'h4026;
    localparam logic [14:0] ADDR_STATUS     = 15'h4030;
    localparam logic [14:0] ADDR_READ_DATA  = 15'h4031;
    localparam logic [14:0] ADDR_DRIVE_STAT = 15'h4032;
    localparam logic [14:0] ADDR_CONN_READ  = 15'h4033;

    localparam int ST_TRANSFER = 0;
    localparam int ST_EOH      = 1;
    localparam int ST_READY    = 2;
    localparam int ST_DISKINT  = 3;
    localparam int ST_GAP      = 4;

    localparam int CB_MOTOR  = 0;
    localparam int CB_RESET  = 1;
    localparam int CB_READ   = 2;
    localparam int CB_MIRROR = 3;
    localparam int CB_CRC    = 4;
    localparam int CB_DREADY = 5;
    localparam int CB_DIRQ   = 6;

endpackage

@@ sv/disk_drive_controller_timer_top.sv @@
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_mode, i_address, i_write_value, i_disk_byte
// result    out        o_valid / i_stall  o_read_data .. o_sound_enable
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
// One word per cycle while o_stall is low: each word updates the register file and
// the result register in the same cycle; o_valid is set in the cycle after acceptance.
// Synchronous active-low reset clears state (not result payload), loads config defaults.
// o_stall is high only while a result is held and the output side stalls.
module disk_drive_controller_timer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_mode,
    input  logic [14:0]                    i_address,
    input  logic [7:0]                     i_write_value,
    input  logic [7:0]                     i_disk_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_read_data,
    output logic                           o_timer_irq,
    output logic                           o_disk_irq,
    output logic [19:0]                    o_disk_address,
    output logic                           o_disk_write_en,
    output logic [7:0]                     o_disk_write_byte,
    output logic                           o_mirror_horizontal,
    output logic                           o_sound_enable,
    input  logic                           i_cfg_we,
    input  logic [ddct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddct_pkg::*;

    logic [15:0] r_spinup_delay, r_byte_delay, r_side_length;
    logic [2:0]  r_disk_side;
    logic        r_disk_missing, r_write_protect;

    logic [15:0] r_timer_reload, r_timer_count, r_head_position, r_wait_count;
    logic        r_timer_repeat, r_timer_enabled, r_timer_pending;
    logic        r_disk_io_enabled, r_sound_io_enabled;
    logic [6:0]  r_control_bits, r_connector_bits;
    logic [7:0]  r_outgoing_byte, r_incoming_byte;
    logic [4:0]  r_status_flags;

    logic [15:0] n_timer_reload, n_timer_count, n_head_position, n_wait_count;
    logic        n_timer_repeat, n_timer_enabled, n_timer_pending;
    logic        n_disk_io_enabled, n_sound_io_enabled;
    logic [6:0]  n_control_bits, n_connector_bits;
    logic [7:0]  n_outgoing_byte, n_incoming_byte;
    logic [4:0]  n_status_flags;

    logic        r_out_valid;
    logic [7:0]  r_read_data, r_disk_write_byte;
    logic        r_timer_irq, r_disk_irq, r_disk_write_en, r_mirror, r_sound;
    logic [19:0] r_disk_address;

    logic [7:0]  n_read_data, n_disk_write_byte;
    logic        n_disk_write_en;
    logic [19:0] n_disk_address;

    logic        accept;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        logic        parked;
        logic        irq_ok;
        logic        accessed;
        logic [15:0] acc_pos;
        logic [7:0]  tmp;

        n_timer_reload     = r_timer_reload;
        n_timer_count      = r_timer_count;
        n_timer_repeat     = r_timer_repeat;
        n_timer_enabled    = r_timer_enabled;
        n_timer_pending    = r_timer_pending;
        n_disk_io_enabled  = r_disk_io_enabled;
        n_sound_io_enabled = r_sound_io_enabled;
        n_control_bits     = r_control_bits;
        n_connector_bits   = r_connector_bits;
        n_outgoing_byte    = r_outgoing_byte;
        n_incoming_byte    = r_incoming_byte;
        n_status_flags     = r_status_flags;
        n_head_position    = r_head_position;
        n_wait_count       = r_wait_count;
        n_read_data        = 8'd0;
        n_disk_write_en    = 1'b0;
        n_disk_write_byte  = 8'd0;
        parked             = 1'b0;
        irq_ok             = r_control_bits[CB_DIRQ];
        accessed           = 1'b0;
        acc_pos            = 16'd0;
        tmp                = 8'd0;

        unique case (i_mode)
            MODE_READ: begin
                if (i_address == ADDR_STATUS) begin
                    n_read_data = {r_disk_io_enabled, r_status_flags[ST_EOH], 4'd0,
                                   r_status_flags[ST_TRANSFER], r_timer_pending};
                    n_timer_pending = 1'b0;
                    n_status_flags[ST_DISKINT]  = 1'b0;
                    n_status_flags[ST_TRANSFER] = 1'b0;
                end else if (i_address == ADDR_READ_DATA) begin
                    n_read_data = r_incoming_byte;
                    n_status_flags[ST_DISKINT]  = 1'b0;
                    n_status_flags[ST_TRANSFER] = 1'b0;
                end else if (i_address == ADDR_DRIVE_STAT) begin
                    n_read_data = {5'd0, r_write_protect, r_status_flags[ST_READY],
                                   r_disk_missing};
                end else if (i_address == ADDR_CONN_READ) begin
                    n_read_data = {1'b1, r_connector_bits};
                end
            end
            MODE_WRITE: begin
                if (i_address == ADDR_TIMER_LO) begin
                    n_timer_reload[7:0] = i_write_value;
                end else if (i_address == ADDR_TIMER_HI) begin
                    n_timer_reload[15:8] = i_write_value;
                end else if (i_address == ADDR_TIMER_CTRL) begin
                    n_timer_enabled = r_disk_io_enabled & i_write_value[1];
                    n_timer_repeat  = i_write_value[0];
                    if (n_timer_enabled) begin
                        n_timer_count = r_timer_reload;
                    end else begin
                        n_timer_pending = 1'b0;
                    end
                end else if (i_address == ADDR_MASTER_IO) begin
                    n_disk_io_enabled  = i_write_value[0];
                    n_sound_io_enabled = i_write_value[1];
                    if (!i_write_value[0]) begin
                        n_timer_enabled = 1'b0;
                        n_timer_pending = 1'b0;
                        n_status_flags[ST_DISKINT] = 1'b0;
                    end
                end else if (i_address == ADDR_WRITE_DATA) begin
                    n_outgoing_byte = i_write_value;
                    n_status_flags[ST_TRANSFER] = 1'b0;
                    n_status_flags[ST_DISKINT]  = 1'b0;
                end else if (i_address == ADDR_CONTROL) begin
                    n_status_flags[ST_DISKINT] = 1'b0;
                    n_control_bits = {i_write_value[7:6], i_write_value[4:0]};
                end else if (i_address == ADDR_CONNECTOR) begin
                    n_connector_bits = i_write_value[6:0];
                end
            end
            MODE_TICK: begin
                if (r_timer_enabled) begin
                    if (r_timer_count == 16'd0) begin
                        n_timer_pending = 1'b1;
                        n_timer_count   = r_timer_reload;
                        if (!r_timer_repeat) begin
                            n_timer_enabled = 1'b0;
                        end
                    end else begin
                        n_timer_count = r_timer_count - 16'd1;
                    end
                end

                if (!r_control_bits[CB_MOTOR]) begin
                    n_status_flags[ST_EOH]   = 1'b1;
                    n_status_flags[ST_READY] = 1'b1;
                    parked = 1'b1;
                end
                if (r_control_bits[CB_RESET] && n_status_flags[ST_READY]) begin
                    parked = 1'b1;
                end

                if (!parked) begin
                    if (n_status_flags[ST_EOH]) begin
                        n_wait_count = r_spinup_delay;
                        n_status_flags[ST_GAP] = 1'b0;
                        n_status_flags[ST_EOH] = 1'b0;
                        n_head_position = 16'd0;
                    end
                    if (n_wait_count != 16'd0) begin
                        n_wait_count = n_wait_count - 16'd1;
                    end else begin
                        n_status_flags[ST_READY] = 1'b0;
                        accessed = 1'b1;
                        acc_pos  = n_head_position;
                        if (r_control_bits[CB_READ]) begin
                            if (!r_control_bits[CB_DREADY]) begin
                                n_status_flags[ST_GAP] = 1'b0;
                            end else if (i_disk_byte != 8'd0 && !n_status_flags[ST_GAP]) begin
                                n_status_flags[ST_GAP] = 1'b1;
                                irq_ok = 1'b0;
                            end
                            if (n_status_flags[ST_GAP]) begin
                                n_status_flags[ST_TRANSFER] = 1'b1;
                                n_incoming_byte = i_disk_byte;
                                if (irq_ok) begin
                                    n_status_flags[ST_DISKINT] = 1'b1;
                                end
                            end
                        end else begin
                            if (!r_control_bits[CB_CRC]) begin
                                n_status_flags[ST_TRANSFER] = 1'b1;
                                tmp = r_outgoing_byte;
                                if (irq_ok) begin
                                    n_status_flags[ST_DISKINT] = 1'b1;
                                end
                            end
                            if (!r_control_bits[CB_DREADY]) begin
                                tmp = 8'd0;
                            end
                            n_disk_write_en   = 1'b1;
                            n_disk_write_byte = tmp;
                        end
                        n_head_position = n_head_position + 16'd1;
                        if (n_head_position >= r_side_length) begin
                            n_control_bits[CB_MOTOR] = 1'b0;
                        end else begin
                            n_wait_count = r_byte_delay;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_disk_address = accessed ? {r_disk_side, 1'b0, acc_pos}
                                  : {r_disk_side, 1'b0, n_head_position};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spinup_delay  <= SPINUP_DELAY_RST;
            r_byte_delay    <= BYTE_DELAY_RST;
            r_side_length   <= SIDE_LENGTH_RST;
            r_disk_side     <= 3'd0;
            r_disk_missing  <= 1'b0;
            r_write_protect <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPINUP_DELAY:  r_spinup_delay  <= i_cfg_data;
                CFG_BYTE_DELAY:    r_byte_delay    <= i_cfg_data;
                CFG_SIDE_LENGTH:   r_side_length   <= i_cfg_data;
                CFG_DISK_SIDE:     r_disk_side     <= i_cfg_data[2:0];
                CFG_DISK_MISSING:  r_disk_missing  <= i_cfg_data[0];
                CFG_WRITE_PROTECT: r_write_protect <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_reload     <= 16'd0;
            r_timer_count      <= 16'd0;
            r_timer_repeat     <= 1'b0;
            r_timer_enabled    <= 1'b0;
            r_timer_pending    <= 1'b0;
            r_disk_io_enabled  <= 1'b0;
            r_sound_io_enabled <= 1'b0;
            r_control_bits     <= 7'd0;
            r_connector_bits   <= 7'd0;
            r_outgoing_byte    <= 8'd0;
            r_incoming_byte    <= 8'd0;
            r_status_flags     <= 5'd0;
            r_head_position    <= 16'd0;
            r_wait_count       <= 16'd0;
            r_out_valid        <= 1'b0;
        end else begin
            if (accept) begin
                r_timer_reload     <= n_timer_reload;
                r_timer_count      <= n_timer_count;
                r_timer_repeat     <= n_timer_repeat;
                r_timer_enabled    <= n_timer_enabled;
                r_timer_pending    <= n_timer_pending;
                r_disk_io_enabled  <= n_disk_io_enabled;
                r_sound_io_enabled <= n_sound_io_enabled;
                r_control_bits     <= n_control_bits;
                r_connector_bits   <= n_connector_bits;
                r_outgoing_byte    <= n_outgoing_byte;
                r_incoming_byte    <= n_incoming_byte;
                r_status_flags     <= n_status_flags;
                r_head_position    <= n_head_position;
                r_wait_count       <= n_wait_count;
                r_out_valid        <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data       <= n_read_data;
            r_timer_irq       <= n_timer_pending;
            r_disk_irq        <= n_status_flags[ST_DISKINT];
            r_disk_address    <= n_disk_address;
            r_disk_write_en   <= n_disk_write_en;
            r_disk_write_byte <= n_disk_write_byte;
            r_mirror          <= n_control_bits[CB_MIRROR];
            r_sound           <= n_sound_io_enabled;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_timer_irq         = r_timer_irq;
    assign o_disk_irq          = r_disk_irq;
    assign o_disk_address      = r_disk_address;
    assign o_disk_write_en     = r_disk_write_en;
    assign o_disk_write_byte   = r_disk_write_byte;
    assign o_mirror_horizontal = r_mirror;
    assign o_sound_enable      = r_sound;

endmodule

@@ tb/sv/disk_drive_controller_timer_top_tb.sv @@
module disk_drive_controller_timer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddct_pkg::*;

    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [14:0] ADDR_NONE_LO = 15'h0000;
    localparam logic [14:0] ADDR_NONE_HI = 15'h7fff;
    localparam int          PHASES       = 8;
    localparam int          PHASE_WORDS  = 185;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DIR_ROWS     = 26;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        timer_irq;
        logic        disk_irq;
        logic [19:0] disk_address;
        logic        write_en;
        logic [7:0]  write_byte;
        logic        mirror;
        logic        sound;
    } t_result;

    // pinned rows expect every field not listed here to be zero
    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] address;
        logic [7:0]  value;
        logic [7:0]  disk_byte;
        logic        pinned;
        logic [7:0]  exp_read;
        logic        exp_timer;
        logic        exp_sound;
    } t_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_mode        = MODE_READ;
    logic [14:0]           i_address     = '0;
    logic [7:0]            i_write_value = '0;
    logic [7:0]            i_disk_byte   = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [7:0]            o_read_data;
    logic                  o_timer_irq;
    logic                  o_disk_irq;
    logic [19:0]           o_disk_address;
    logic                  o_disk_write_en;
    logic [7:0]            o_disk_write_byte;
    logic                  o_mirror_horizontal;
    logic                  o_sound_enable;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic    pin_en   = 1'b0;
    t_result pin_want = '0;

    int send_idle  = 0;
    int recv_stall = 0;
    int words_sent = 0;
    int words_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int bytes_stepped = 0;
    int timer_fires = 0;

    t_result expq[$];

    // drive model state
    logic [15:0] cfg_spinup, cfg_gap, cfg_len;
    logic [2:0]  cfg_side;
    logic        cfg_missing, cfg_wprot;
    logic [15:0] tmr_reload, tmr_count;
    logic        tmr_repeat, tmr_on, tmr_irq;
    logic        dio_on, snd_on;
    logic [6:0]  ctrl;
    logic [7:0]  out_byte, in_byte;
    logic [6:0]  conn;
    logic [4:0]  flags;
    logic [15:0] head, wait_cnt;

    t_row dir_rows [DIR_ROWS] = '{
        '{MODE_READ,   ADDR_STATUS,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,   ADDR_CONN_READ,  8'h00, 8'h00, 1'b1, 8'h80, 1'b0, 1'b0},
        '{MODE_TICK,   ADDR_NONE_HI,    8'hff, 8'hff, 1'b1, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,   ADDR_DRIVE_STAT, 8'h00, 8'h00, 1'b1, 8'h02, 1'b0, 1'b0},
        '{MODE_READ,   ADDR_STATUS,     8'h00, 8'h00, 1'b1, 8'h40, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_MASTER_IO,  8'hff, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
        '{MODE_WRITE,  ADDR_CONNECTOR,  8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,   ADDR_CONN_READ,  8'h00, 8'h00, 1'b1, 8'hff, 1'b0, 1'b1},
        '{MODE_WRITE,  ADDR_TIMER_LO,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_TIMER_HI,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_TIMER_CTRL, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TICK,   ADDR_TIMER_LO,   8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1},
        '{MODE_READ,   ADDR_STATUS,     8'h00, 8'h00, 1'b1, 8'hc1, 1'b0, 1'b1},
        '{MODE_WRITE,  ADDR_TIMER_LO,   8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_TIMER_HI,   8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_TIMER_CTRL, 8'h03, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TICK,   ADDR_STATUS,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_CONTROL,    8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TICK,   ADDR_CONTROL,    8'h00, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_CONTROL,    8'hc5, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_TICK,   ADDR_NONE_LO,    8'h00, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_MASTER_IO,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_TIMER_CTRL, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_READ,   ADDR_NONE_HI,    8'hff, 8'hff, 1'b1, 8'h00, 1'b0, 1'b0},
        '{MODE_WRITE,  ADDR_NONE_LO,    8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{MODE_UNUSED, ADDR_READ_DATA,  8'hff, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    disk_drive_controller_timer_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_address           (i_address),
        .i_write_value       (i_write_value),
        .i_disk_byte         (i_disk_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_read_data         (o_read_data),
        .o_timer_irq         (o_timer_irq),
        .o_disk_irq          (o_disk_irq),
        .o_disk_address      (o_disk_address),
        .o_disk_write_en     (o_disk_write_en),
        .o_disk_write_byte   (o_disk_write_byte),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_sound_enable      (o_sound_enable),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result drive_step(logic [1:0] m, logic [14:0] a, logic [7:0] v,
                                           logic [7:0] db);
        t_result r;
        logic    parked;
        logic    irq_ok;
        logic    stepped;
        logic [7:0] b;
        r = '0;
        stepped = 1'b0;
        if (m == MODE_READ) begin
            unique case (a)
                ADDR_STATUS: begin
                    r.read_data = {dio_on, flags[ST_EOH], 4'b0000, flags[ST_TRANSFER], tmr_irq};
                    tmr_irq = 1'b0;
                    flags[ST_DISKINT] = 1'b0;
                    flags[ST_TRANSFER] = 1'b0;
                end
                ADDR_READ_DATA: begin
                    r.read_data = in_byte;
                    flags[ST_DISKINT] = 1'b0;
                    flags[ST_TRANSFER] = 1'b0;
                end
                ADDR_DRIVE_STAT: r.read_data = {5'b00000, cfg_wprot, flags[ST_READY], cfg_missing};
                ADDR_CONN_READ:  r.read_data = {1'b1, conn};
                default: ;
            endcase
        end else if (m == MODE_WRITE) begin
            unique case (a)
                ADDR_TIMER_LO: tmr_reload[7:0] = v;
                ADDR_TIMER_HI: tmr_reload[15:8] = v;
                ADDR_TIMER_CTRL: begin
                    tmr_on = dio_on & v[1];
                    tmr_repeat = v[0];
                    if (tmr_on) begin
                        tmr_count = tmr_reload;
                    end else begin
                        tmr_irq = 1'b0;
                    end
                end
                ADDR_MASTER_IO: begin
                    dio_on = v[0];
                    snd_on = v[1];
                    if (!dio_on) begin
                        tmr_on = 1'b0;
                        tmr_irq = 1'b0;
                        flags[ST_DISKINT] = 1'b0;
                    end
                end
                ADDR_WRITE_DATA: begin
                    out_byte = v;
                    flags[ST_TRANSFER] = 1'b0;
                    flags[ST_DISKINT] = 1'b0;
                end
                ADDR_CONTROL: begin
                    flags[ST_DISKINT] = 1'b0;
                    ctrl = {v[7:6], v[4:0]};
                end
                ADDR_CONNECTOR: conn = v[6:0];
                default: ;
            endcase
        end else if (m == MODE_TICK) begin
            if (tmr_on) begin
                if (tmr_count == 16'd0) begin
                    tmr_irq = 1'b1;
                    timer_fires++;
                    tmr_count = tmr_reload;
                    if (!tmr_repeat) begin
                        tmr_on = 1'b0;
                    end
                end else begin
                    tmr_count = tmr_count - 16'd1;
                end
            end
            irq_ok = ctrl[CB_DIRQ];
            parked = 1'b0;
            if (!ctrl[CB_MOTOR]) begin
                flags[ST_EOH] = 1'b1;
                flags[ST_READY] = 1'b1;
                parked = 1'b1;
            end
            if (ctrl[CB_RESET] && flags[ST_READY]) begin
                parked = 1'b1;
            end
            if (!parked) begin
                if (flags[ST_EOH]) begin
                    wait_cnt = cfg_spinup;
                    flags[ST_GAP] = 1'b0;
                    flags[ST_EOH] = 1'b0;
                    head = '0;
                end
                if (wait_cnt != 16'd0) begin
                    wait_cnt = wait_cnt - 16'd1;
                end else begin
                    stepped = 1'b1;
                    bytes_stepped++;
                    flags[ST_READY] = 1'b0;
                    r.disk_address = {cfg_side, 1'b0, head};
                    if (ctrl[CB_READ]) begin
                        b = db;
                        if (!ctrl[CB_DREADY]) begin
                            flags[ST_GAP] = 1'b0;
                        end else if (b != 8'h00 && !flags[ST_GAP]) begin
                            flags[ST_GAP] = 1'b1;
                            irq_ok = 1'b0;
                        end
                        if (flags[ST_GAP]) begin
                            flags[ST_TRANSFER] = 1'b1;
                            in_byte = b;
                            if (irq_ok) begin
                                flags[ST_DISKINT] = 1'b1;
                            end
                        end
                    end else begin
                        b = 8'h00;
                        if (!ctrl[CB_CRC]) begin
                            flags[ST_TRANSFER] = 1'b1;
                            b = out_byte;
                            if (irq_ok) begin
                                flags[ST_DISKINT] = 1'b1;
                            end
                        end
                        if (!ctrl[CB_DREADY]) begin
                            b = 8'h00;
                        end
                        r.write_en = 1'b1;
                        r.write_byte = b;
                    end
                    head = head + 16'd1;
                    if (head >= cfg_len) begin
                        ctrl[CB_MOTOR] = 1'b0;
                    end else begin
                        wait_cnt = cfg_gap;
                    end
                end
            end
        end
        if (!stepped) begin
            r.disk_address = {cfg_side, 1'b0, head};
        end
        r.timer_irq = tmr_irq;
        r.disk_irq = flags[ST_DISKINT];
        r.mirror = ctrl[CB_MIRROR];
        r.sound = snd_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SPINUP_DELAY:  cfg_spinup = i_cfg_data;
                    CFG_BYTE_DELAY:    cfg_gap = i_cfg_data;
                    CFG_SIDE_LENGTH:   cfg_len = i_cfg_data;
                    CFG_DISK_SIDE:     cfg_side = i_cfg_data[2:0];
                    CFG_DISK_MISSING:  cfg_missing = i_cfg_data[0];
                    CFG_WRITE_PROTECT: cfg_wprot = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                want = drive_step(i_mode, i_address, i_write_value, i_disk_byte);
                words_taken++;
                expq.push_back(pin_en ? pin_want : want);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                got = '{o_read_data, o_timer_irq, o_disk_irq, o_disk_address,
                        o_disk_write_en, o_disk_write_byte, o_mirror_horizontal,
                        o_sound_enable};
                if (expq.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word with nothing expected, got %h", $time, got);
                end else begin
                    want = expq.pop_front();
                    results_seen++;
                    check_field("read_data", 20'(want.read_data), 20'(got.read_data));
                    check_field("timer_irq", 20'(want.timer_irq), 20'(got.timer_irq));
                    check_field("disk_irq", 20'(want.disk_irq), 20'(got.disk_irq));
                    check_field("disk_address", want.disk_address, got.disk_address);
                    check_field("disk_write_en", 20'(want.write_en), 20'(got.write_en));
                    check_field("disk_write_byte", 20'(want.write_byte),
                                20'(got.write_byte));
                    check_field("mirror_horizontal", 20'(want.mirror), 20'(got.mirror));
                    check_field("sound_enable", 20'(want.sound), 20'(got.sound));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_word(input logic [1:0] m, input logic [14:0] a, input logic [7:0] v,
                             input logic [7:0] db, input logic pin, input t_result want);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= m;
        i_address     <= a;
        i_write_value <= v;
        i_disk_byte   <= db;
        pin_en        <= pin;
        pin_want      <= want;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expq.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] spin, input logic [15:0] gap,
                              input logic [15:0] len, input logic [2:0] side,
                              input logic missing, input logic wprot);
        write_reg(CFG_SPINUP_DELAY, spin);
        write_reg(CFG_BYTE_DELAY, gap);
        write_reg(CFG_SIDE_LENGTH, len);
        write_reg(CFG_DISK_SIDE, {13'd0, side});
        write_reg(CFG_DISK_MISSING, {15'd0, missing});
        write_reg(CFG_WRITE_PROTECT, {15'd0, wprot});
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] disk_pick();
        return ($urandom_range(9) < 4) ? 8'h00 : 8'($urandom);
    endfunction

    task automatic send_burst();
        int r;
        int n;
        logic [7:0] v;
        r = $urandom_range(99);
        if (r < 65) begin
            // motor mostly on, transfer reset rarely
            v = 8'($urandom);
            v[0] = ($urandom_range(9) != 0);
            v[1] = ($urandom_range(5) == 0);
            send_word(MODE_WRITE, ADDR_CONTROL, v, 8'($urandom), 1'b0, '0);
            n = $urandom_range(10, 40);
            repeat (n) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    send_word(MODE_TICK, 15'($urandom), 8'($urandom), disk_pick(), 1'b0, '0);
                end else if (r < 88) begin
                    send_word(MODE_READ, $urandom_range(1) ? ADDR_STATUS : ADDR_READ_DATA,
                              8'($urandom), 8'($urandom), 1'b0, '0);
                end else begin
                    send_word(MODE_WRITE, ADDR_WRITE_DATA, 8'($urandom), 8'($urandom),
                              1'b0, '0);
                end
            end
        end else if (r < 80) begin
            send_word(MODE_WRITE, ADDR_TIMER_LO, 8'($urandom_range(0, 40)), 8'($urandom),
                      1'b0, '0);
            send_word(MODE_WRITE, ADDR_TIMER_HI,
                      ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00, 8'($urandom), 1'b0, '0);
            send_word(MODE_WRITE, ADDR_TIMER_CTRL, 8'($urandom), 8'($urandom), 1'b0, '0);
            n = $urandom_range(5, 30);
            repeat (n) begin
                send_word(MODE_TICK, 15'($urandom), 8'($urandom), disk_pick(), 1'b0, '0);
            end
        end else if (r < 88) begin
            // park the head so the next motor start spins up again
            v = 8'($urandom);
            v[0] = ($urandom_range(7) != 0);
            send_word(MODE_WRITE, ADDR_MASTER_IO, v, 8'($urandom), 1'b0, '0);
            v = 8'($urandom);
            v[0] = 1'b0;
            send_word(MODE_WRITE, ADDR_CONTROL, v, 8'($urandom), 1'b0, '0);
            send_word(MODE_TICK, 15'($urandom), 8'($urandom), disk_pick(), 1'b0, '0);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                send_word(2'($urandom),
                          $urandom_range(1) ? 15'($urandom_range(ADDR_TIMER_LO, ADDR_CONN_READ))
                                            : 15'($urandom),
                          8'($urandom), 8'($urandom), 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        int      ph;
        int      goal;
        int      half;
        bit      paused;
        t_result want;
        cfg_spinup  = SPINUP_DELAY_RST;
        cfg_gap     = BYTE_DELAY_RST;
        cfg_len     = SIDE_LENGTH_RST;
        cfg_side    = '0;
        cfg_missing = 1'b0;
        cfg_wprot   = 1'b0;
        tmr_reload  = '0;
        tmr_count   = '0;
        tmr_repeat  = 1'b0;
        tmr_on      = 1'b0;
        tmr_irq     = 1'b0;
        dio_on      = 1'b0;
        snd_on      = 1'b0;
        ctrl        = '0;
        out_byte    = '0;
        in_byte     = '0;
        conn        = '0;
        flags       = '0;
        head        = '0;
        wait_cnt    = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            want = '0;
            want.read_data = dir_rows[k].exp_read;
            want.timer_irq = dir_rows[k].exp_timer;
            want.sound     = dir_rows[k].exp_sound;
            send_word(dir_rows[k].mode, dir_rows[k].address, dir_rows[k].value,
                      dir_rows[k].disk_byte, dir_rows[k].pinned, want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            unique case (ph)
                0: set_config(16'd0, 16'd0, 16'd1, 3'd7, 1'b1, 1'b1);
                1: set_config(16'hffff, 16'hffff, 16'hffff, 3'd0, 1'b0, 1'b0);
                2: set_config(16'd0, 16'd0, 16'd0, 3'd3, 1'b0, 1'b1);
                3: set_config(16'd3, 16'd2, 16'd20, 3'd5, 1'b1, 1'b0);
                default: set_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
                                    16'($urandom_range(1, 60)), 3'($urandom),
                                    1'($urandom), 1'($urandom));
            endcase
            unique case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase
            goal = words_sent + PHASE_WORDS;
            half = words_sent + PHASE_WORDS / 2;
            paused = 1'b0;
            while (words_sent < goal) begin
                if (!paused && words_sent >= half) begin
                    settle();
                    paused = 1'b1;
                end
                send_burst();
            end
        end

        settle();
        repeat (4) @(negedge i_clk);

        $display("%0d words sent, %0d results checked over %0d configurations",
                 words_taken, results_seen, PHASES + 1);
        $display("%0d disk bytes stepped, %0d timer expiries, %0d mismatches",
                 bytes_stepped, timer_fires, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
